// ----- src/pris_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pris_pkg;

   // default widths of the internal datapath
   localparam int COORD_WIDTH_DEF = 32;
   localparam int SCORE_WIDTH_DEF = 40;

   // port field widths
   localparam int WORD_W     = 32;
   localparam int DIST_W     = 24;
   localparam int OUT_SCORE_W = 40;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // pose storage
   localparam int POSE_WORDS = 12;
   localparam int ROT_WORDS  = 9;

   // 3d rule ratio
   localparam int DEPTH_RATIO = 5;

   // action codes
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_POINT = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_FOCAL_X   = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y   = 3'd1;
   localparam logic [2:0] REG_CENTER_X  = 3'd2;
   localparam logic [2:0] REG_CENTER_Y  = 3'd3;
   localparam logic [2:0] REG_DIST      = 3'd4;
   localparam logic [2:0] REG_DIST_3D   = 3'd5;
   localparam logic [2:0] REG_DEPTH_MODE = 3'd6;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROT_INIT,
      ST_ROT_MUL,
      ST_ROT_ACC,
      ST_CAM_CHK,
      ST_DIV_INIT,
      ST_DIV,
      ST_PROJ_MUL,
      ST_PROJ_ACC,
      ST_RNG_CHK,
      ST_SQ_U,
      ST_SQ_V,
      ST_SQ_R,
      ST_DIST_CHK,
      ST_SQRT,
      ST_SCORE,
      ST_D3_MUL,
      ST_D3_TT,
      ST_D3_CMP
   } state_type;

endpackage

`default_nettype wire

// ----- src/pris_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pris_req_if import pris_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [3:0]        pose_index;
   logic signed [WORD_W-1:0] pose_value;
   logic signed [WORD_W-1:0] model_x;
   logic signed [WORD_W-1:0] model_y;
   logic signed [WORD_W-1:0] model_z;
   logic signed [WORD_W-1:0] image_u;
   logic signed [WORD_W-1:0] image_v;
   logic              image_has_depth;
   logic signed [WORD_W-1:0] image_x;
   logic signed [WORD_W-1:0] image_y;
   logic signed [WORD_W-1:0] image_z;

   modport source (
      output valid, action, pose_index, pose_value, model_x, model_y, model_z,
             image_u, image_v, image_has_depth, image_x, image_y, image_z,
      input  ready
   );

   modport sink (
      input  valid, action, pose_index, pose_value, model_x, model_y, model_z,
             image_u, image_v, image_has_depth, image_x, image_y, image_z,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/pris_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pris_rsp_if import pris_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [OUT_SCORE_W-1:0] score;
   logic                   behind_camera;
   logic                   depth_rejected;

   modport source (
      output valid, score, behind_camera, depth_rejected,
      input  ready
   );

   modport sink (
      input  valid, score, behind_camera, depth_rejected,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/pose_reprojection_inlier_score.sv -----
`timescale 1ns / 1ps
`default_nettype none
// load and end beats are taken in idle; a point beat holds ready low until it is done (sooner
// on early exit), its time set by the shared 33x33 multiplier, the bit-serial divider (used
// for each image axis) and the bit-serial square root; one item at a time
// an end beat's result sits in an output register; no beat is taken until it is accepted
// synchronous active-high reset clears registers, pose, sums and the abort flag

module pose_reprojection_inlier_score import pris_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int SCORE_WIDTH = SCORE_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pris_req_if.sink                   req_bus,
   pris_rsp_if.source                 rsp_bus,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int CW    = COORD_WIDTH;
   localparam int SW    = SCORE_WIDTH;
   localparam int ACC_W = 38;
   localparam int SAT_W = (CW > ACC_W) ? CW : ACC_W;
   localparam int DW    = 51;
   localparam int DIF_W = ((CW > WORD_W) ? CW : WORD_W) + 1;
   localparam int MUL_W = 33;
   localparam int PRD_W = 2 * MUL_W;

   // configuration registers
   logic [WORD_W-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [DIST_W-1:0] dist_r_ff;
   logic [WORD_W-1:0] dist_3d_ff;
   logic              mode_ff;

   // pass state
   logic [WORD_W-1:0] pose_ff [POSE_WORDS];
   logic [SW-1:0]     score_ff, score_in;
   logic [SW-1:0]     depth_ff, depth_in;
   logic              aborted_ff, aborted_in;

   // sequencer
   state_type         state_ff, state_in;
   logic [1:0]        row_ff, row_in, col_ff, col_in, axis_ff, axis_in;
   logic [4:0]        cnt_ff, cnt_in;

   // latched point
   logic signed [WORD_W-1:0] model_ff [3];
   logic signed [WORD_W-1:0] img3_ff [3];
   logic signed [WORD_W-1:0] img_u_ff, img_v_ff;
   logic              has_depth_ff;
   logic              latch_point;

   // datapath registers
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [CW-1:0]    cam_ff [3];
   logic signed [CW-1:0]    cam_in [3];
   logic signed [PRD_W-1:0] prod_ff;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [CW:0]             rem_ff, rem_in;
   logic [WORD_W-1:0]       quo_ff, quo_in, lo_ff, lo_in;
   logic signed [DW-1:0]    du_ff, du_in, dv_ff, dv_in;
   logic [48:0]             dist_ff, dist_in;
   logic [25:0]             srem_ff, srem_in;
   logic [DIST_W-1:0]       root_ff, root_in;
   logic [65:0]             d3_ff, d3_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                   rsp_behind_ff, rsp_behind_in;
   logic                   rsp_rej_ff, rsp_rej_in;

   logic req_fire;
   logic pose_we;

   // csr port
   logic       csr_we;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_we  = psel && penable && pwrite && pready;

   always_comb begin
      case (csr_idx)
         REG_FOCAL_X:    prdata = focal_x_ff;
         REG_FOCAL_Y:    prdata = focal_y_ff;
         REG_CENTER_X:   prdata = center_x_ff;
         REG_CENTER_Y:   prdata = center_y_ff;
         REG_DIST:       prdata = CSR_DATA_W'(dist_r_ff);
         REG_DIST_3D:    prdata = dist_3d_ff;
         REG_DEPTH_MODE: prdata = CSR_DATA_W'(mode_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= '0;
         focal_y_ff  <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
         dist_r_ff   <= '0;
         dist_3d_ff  <= '0;
         mode_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_idx)
            REG_FOCAL_X:    focal_x_ff  <= pwdata;
            REG_FOCAL_Y:    focal_y_ff  <= pwdata;
            REG_CENTER_X:   center_x_ff <= pwdata;
            REG_CENTER_Y:   center_y_ff <= pwdata;
            REG_DIST:       dist_r_ff   <= pwdata[DIST_W-1:0];
            REG_DIST_3D:    dist_3d_ff  <= pwdata;
            REG_DEPTH_MODE: mode_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.score          = rsp_score_ff;
   assign rsp_bus.behind_camera  = rsp_behind_ff;
   assign rsp_bus.depth_rejected = rsp_rej_ff;

   // pose read port, one address per cycle
   logic [3:0]        pose_rd_idx;
   logic [WORD_W-1:0] pose_rd;
   always_comb begin
      if (state_ff == ST_ROT_INIT) begin
         pose_rd_idx = 4'(ROT_WORDS) + 4'(row_ff);
      end else begin
         pose_rd_idx = {1'b0, row_ff, 1'b0} + 4'(row_ff) + 4'(col_ff);
      end
   end
   assign pose_rd = pose_ff[pose_rd_idx];

   // rotation accumulate with floor shift and saturation
   logic signed [ACC_W-1:0] rot_sum;
   logic signed [SAT_W-1:0] rot_wide, lim_hi, lim_lo;
   logic signed [CW-1:0]    rot_sat;
   assign rot_sum  = acc_ff + ACC_W'(prod_ff >>> 30);
   assign rot_wide = SAT_W'(rot_sum);
   assign lim_hi   = (SAT_W'(1) <<< (CW - 1)) - SAT_W'(1);
   assign lim_lo   = -lim_hi - SAT_W'(1);
   always_comb begin
      if (rot_wide > lim_hi) begin
         rot_sat = CW'(lim_hi);
      end else if (rot_wide < lim_lo) begin
         rot_sat = CW'(lim_lo);
      end else begin
         rot_sat = CW'(rot_wide);
      end
   end

   // divider operands
   logic signed [CW-1:0] a_sel;
   logic [CW-1:0]        a_mag, z_mag;
   logic                 div_sat;
   logic [CW:0]          div_trial;
   logic                 div_ge;
   assign a_sel     = axis_ff[0] ? cam_ff[1] : cam_ff[0];
   assign a_mag     = a_sel[CW-1] ? CW'(-a_sel) : CW'(a_sel);
   assign z_mag     = cam_ff[2][CW-1] ? CW'(-cam_ff[2]) : CW'(cam_ff[2]);
   assign div_sat   = {16'h0, a_mag} >= {z_mag, 16'h0};
   assign div_trial = {rem_ff[CW-1:0], lo_ff[WORD_W-1]};
   assign div_ge    = div_trial >= {1'b0, z_mag};

   // projection offset and image residual
   logic [47:0]          proj_off;
   logic signed [DW-1:0] proj_s, proj_res;
   logic                 proj_neg;
   assign proj_off = prod_ff[63:16];
   assign proj_neg = a_sel[CW-1] ^ cam_ff[2][CW-1];
   assign proj_s   = proj_neg ? -$signed({3'b0, proj_off}) : $signed({3'b0, proj_off});
   assign proj_res = proj_s
                   + $signed({19'b0, (axis_ff[0] ? center_y_ff : center_x_ff)})
                   - DW'(axis_ff[0] ? img_v_ff : img_u_ff);

   logic [DW-1:0] du_mag, dv_mag;
   assign du_mag = du_ff[DW-1] ? DW'(-du_ff) : DW'(du_ff);
   assign dv_mag = dv_ff[DW-1] ? DW'(-dv_ff) : DW'(dv_ff);

   // square root digit step
   logic [27:0] sq_remx, sq_trial;
   logic        sq_ge;
   assign sq_remx  = {srem_ff, dist_ff[47:46]};
   assign sq_trial = {2'b0, root_ff, 2'b01};
   assign sq_ge    = sq_remx >= sq_trial;

   // saturating sums
   logic [SW:0] score_add, depth_add;
   assign score_add = {1'b0, score_ff} + (SW + 1)'(dist_r_ff - root_ff);
   assign depth_add = {1'b0, depth_ff} + (SW + 1)'(dist_r_ff);

   // 3d agreement
   logic signed [DIF_W-1:0] d3_diff;
   logic [DIF_W-1:0]        d3_mag;
   assign d3_diff = DIF_W'(cam_ff[axis_ff]) - DIF_W'(img3_ff[axis_ff]);
   assign d3_mag  = d3_diff[DIF_W-1] ? DIF_W'(-d3_diff) : DIF_W'(d3_diff);

   // end-of-pass rule: 5 * depth_sum < score
   logic [SW+2:0] five_depth;
   logic          end_reject;
   assign five_depth = (SW + 3)'(depth_ff) * (SW + 3)'(DEPTH_RATIO);
   assign end_reject = mode_ff && (score_ff != '0) && (five_depth < (SW + 3)'(score_ff));

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      axis_in       = axis_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      cam_in        = cam_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      lo_in         = lo_ff;
      du_in         = du_ff;
      dv_in         = dv_ff;
      dist_in       = dist_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      d3_in         = d3_ff;
      score_in      = score_ff;
      depth_in      = depth_ff;
      aborted_in    = aborted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_score_in  = rsp_score_ff;
      rsp_behind_in = rsp_behind_ff;
      rsp_rej_in    = rsp_rej_ff;
      latch_point   = 1'b0;
      pose_we       = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  ACT_LOAD: begin
                     pose_we = req_bus.pose_index < 4'(POSE_WORDS);
                  end
                  ACT_POINT: begin
                     if (!aborted_ff) begin
                        latch_point = 1'b1;
                        row_in      = '0;
                        state_in    = ST_ROT_INIT;
                     end
                  end
                  ACT_END: begin
                     rsp_valid_in  = 1'b1;
                     rsp_behind_in = aborted_ff;
                     rsp_rej_in    = !aborted_ff && end_reject;
                     rsp_score_in  = (aborted_ff || end_reject) ? '0
                                                                : OUT_SCORE_W'(score_ff);
                     score_in      = '0;
                     depth_in      = '0;
                     aborted_in    = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         // camera coordinates, one product per ROT_MUL and ROT_ACC round
         ST_ROT_INIT: begin
            acc_in   = ACC_W'($signed(pose_rd));
            col_in   = '0;
            state_in = ST_ROT_MUL;
         end
         ST_ROT_MUL: begin
            mul_a    = MUL_W'($signed(pose_rd));
            mul_b    = MUL_W'(model_ff[col_ff]);
            state_in = ST_ROT_ACC;
         end
         ST_ROT_ACC: begin
            acc_in = rot_sum;
            if (col_ff == 2'd2) begin
               cam_in[row_ff] = rot_sat;
               if (row_ff == 2'd2) begin
                  state_in = ST_CAM_CHK;
               end else begin
                  row_in   = row_ff + 2'd1;
                  state_in = ST_ROT_INIT;
               end
            end else begin
               col_in   = col_ff + 2'd1;
               state_in = ST_ROT_MUL;
            end
         end
         ST_CAM_CHK: begin
            axis_in  = '0;
            state_in = (cam_ff[2] == '0) ? ST_IDLE : ST_DIV_INIT;
         end

         // |a| * 2^16 / |z|, saturated to all ones, one quotient bit per cycle
         ST_DIV_INIT: begin
            rem_in = (CW + 1)'(a_mag >> 16);
            lo_in  = {a_mag[15:0], 16'h0};
            cnt_in = 5'd31;
            if (div_sat) begin
               quo_in   = '1;
               state_in = ST_PROJ_MUL;
            end else begin
               quo_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? div_trial - {1'b0, z_mag} : div_trial;
            quo_in = {quo_ff[WORD_W-2:0], div_ge};
            lo_in  = {lo_ff[WORD_W-2:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = ST_PROJ_MUL;
            end
         end
         ST_PROJ_MUL: begin
            mul_a    = {1'b0, (axis_ff[0] ? focal_y_ff : focal_x_ff)};
            mul_b    = {1'b0, quo_ff};
            state_in = ST_PROJ_ACC;
         end
         ST_PROJ_ACC: begin
            if (axis_ff[0]) begin
               dv_in    = proj_res;
               state_in = ST_RNG_CHK;
            end else begin
               du_in    = proj_res;
               axis_in  = 2'd1;
               state_in = ST_DIV_INIT;
            end
         end

         // residual range and squared distance
         ST_RNG_CHK: begin
            if (du_mag >= DW'(dist_r_ff) || dv_mag >= DW'(dist_r_ff)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQ_U;
            end
         end
         ST_SQ_U: begin
            mul_a    = MUL_W'(du_mag[DIST_W-1:0]);
            mul_b    = MUL_W'(du_mag[DIST_W-1:0]);
            state_in = ST_SQ_V;
         end
         ST_SQ_V: begin
            dist_in  = prod_ff[48:0];
            mul_a    = MUL_W'(dv_mag[DIST_W-1:0]);
            mul_b    = MUL_W'(dv_mag[DIST_W-1:0]);
            state_in = ST_SQ_R;
         end
         ST_SQ_R: begin
            dist_in  = dist_ff + prod_ff[48:0];
            mul_a    = MUL_W'(dist_r_ff);
            mul_b    = MUL_W'(dist_r_ff);
            state_in = ST_DIST_CHK;
         end
         ST_DIST_CHK: begin
            srem_in = '0;
            root_in = '0;
            cnt_in  = 5'(DIST_W - 1);
            if (dist_ff >= prod_ff[48:0]) begin
               state_in = ST_IDLE;
            end else if (cam_ff[2][CW-1]) begin
               // inlier behind the camera ends the pass
               aborted_in = 1'b1;
               score_in   = '0;
               depth_in   = '0;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_SQRT;
            end
         end

         // integer root, two radicand bits per cycle
         ST_SQRT: begin
            srem_in = sq_ge ? 26'(sq_remx - sq_trial) : 26'(sq_remx);
            root_in = {root_ff[DIST_W-2:0], sq_ge};
            dist_in = dist_ff << 2;
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = ST_SCORE;
            end
         end
         ST_SCORE: begin
            score_in = score_add[SW] ? '1 : score_add[SW-1:0];
            axis_in  = '0;
            state_in = (mode_ff && has_depth_ff) ? ST_D3_MUL : ST_IDLE;
         end

         // 3d agreement: squared distance against the radius squared
         ST_D3_MUL: begin
            mul_a = MUL_W'(d3_mag[WORD_W-1:0]);
            mul_b = MUL_W'(d3_mag[WORD_W-1:0]);
            d3_in = (axis_ff == '0) ? '0 : d3_ff + 66'(prod_ff[63:0]);
            if (d3_mag >= DIF_W'(dist_3d_ff)) begin
               state_in = ST_IDLE;
            end else if (axis_ff == 2'd2) begin
               state_in = ST_D3_TT;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_D3_TT: begin
            d3_in    = d3_ff + 66'(prod_ff[63:0]);
            mul_a    = {1'b0, dist_3d_ff};
            mul_b    = {1'b0, dist_3d_ff};
            state_in = ST_D3_CMP;
         end
         ST_D3_CMP: begin
            if (d3_ff < 66'(prod_ff[63:0])) begin
               depth_in = depth_add[SW] ? '1 : depth_add[SW-1:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         score_ff     <= '0;
         depth_ff     <= '0;
         aborted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < POSE_WORDS; i++) begin
            pose_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         score_ff     <= score_in;
         depth_ff     <= depth_in;
         aborted_ff   <= aborted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pose_we) begin
            pose_ff[req_bus.pose_index] <= req_bus.pose_value;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      axis_ff       <= axis_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      cam_ff        <= cam_in;
      prod_ff       <= mul_a * mul_b;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      lo_ff         <= lo_in;
      du_ff         <= du_in;
      dv_ff         <= dv_in;
      dist_ff       <= dist_in;
      srem_ff       <= srem_in;
      root_ff       <= root_in;
      d3_ff         <= d3_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_behind_ff <= rsp_behind_in;
      rsp_rej_ff    <= rsp_rej_in;
      if (latch_point) begin
         model_ff[0]  <= req_bus.model_x;
         model_ff[1]  <= req_bus.model_y;
         model_ff[2]  <= req_bus.model_z;
         img3_ff[0]   <= req_bus.image_x;
         img3_ff[1]   <= req_bus.image_y;
         img3_ff[2]   <= req_bus.image_z;
         img_u_ff     <= req_bus.image_u;
         img_v_ff     <= req_bus.image_v;
         has_depth_ff <= req_bus.image_has_depth;
      end
   end

`ifndef NO_ASSERTIONS
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.behind_camera |-> rsp_bus.score == '0 && !rsp_bus.depth_rejected)
      else $error("behind-camera result with nonzero score or reject flag");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.depth_rejected |-> rsp_bus.score == '0)
      else $error("depth-rejected result with nonzero score");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> state_ff == ST_IDLE)
      else $error("input ready while a point is in progress");

   a_abort_clear: assert property (@(posedge clock) disable iff (reset)
      aborted_ff |-> score_ff == '0 && depth_ff == '0)
      else $error("sums nonzero in an aborted pass");
`endif

endmodule

`default_nettype wire

// ----- test/pose_reprojection_inlier_score_test.sv -----
`timescale 1ns / 1ps

module pose_reprojection_inlier_score_test;
   import pris_pkg::*;

   typedef struct {
      logic [1:0]         action;
      logic [3:0]         pose_index;
      logic signed [31:0] pose_value;
      logic signed [31:0] model_x, model_y, model_z;
      logic signed [31:0] image_u, image_v;
      logic               has_depth;
      logic signed [31:0] image_x, image_y, image_z;
   } req_item_type;

   typedef struct {
      logic [OUT_SCORE_W-1:0] score;
      logic                   behind;
      logic                   rejected;
   } score_item_type;

   typedef logic [31:0] pose_type [POSE_WORDS];
   typedef longint vec3_type [3];

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [63:0] SUM_MAX = (64'd1 << SCORE_WIDTH_DEF) - 1;

   logic clock = 0;
   logic reset = 1;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   pris_req_if req ();
   pris_rsp_if rsp ();

   pose_reprojection_inlier_score dut (
      .clock(clock), .reset(reset), .req_bus(req), .rsp_bus(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // camera and threshold settings as the block should hold them
   logic [63:0] cam_fx, cam_fy, cam_cx, cam_cy, radius, radius_3d;
   logic        depth_mode;

   // scoring state as the block should hold it
   pose_type    pose_regs;
   logic [63:0] score_sum, depth_sum;
   logic        aborted;

   // pose the stimulus has loaded so far, used to aim points
   pose_type    gen_pose;

   req_item_type   pending_q[$];
   score_item_type score_q[$];
   req_item_type   cur_item;

   int fails = 0, idle_cycles = 0, gap = 0, stall = 0;
   int n_points = 0, n_scores = 0, n_aborts = 0, n_rejects = 0;
   bit burst = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // known values on all inputs before the first edge
   initial begin
      req.valid = 0; req.action = ACT_LOAD; req.pose_index = 0; req.pose_value = 0;
      req.model_x = 0; req.model_y = 0; req.model_z = 0; req.image_u = 0;
      req.image_v = 0; req.image_has_depth = 0; req.image_x = 0; req.image_y = 0;
      req.image_z = 0; rsp.ready = 0;
   end

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
      if (a > SUM_MAX || b > SUM_MAX - a) return SUM_MAX;
      return a + b;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else res = res >> 1;
         bitv >>= 2;
      end
      return res;
   endfunction

   // camera frame point: rotation products floored to Q16.16, then saturated
   function automatic void to_camera(input pose_type pw, input vec3_type m,
                                     output vec3_type c);
      longint s;
      for (int i = 0; i < 3; i++) begin
         s = longint'($signed(pw[9 + i]));
         for (int j = 0; j < 3; j++)
            s += (longint'($signed(pw[3 * i + j])) * m[j]) >>> 30;
         c[i] = sat32(s);
      end
   endfunction

   function automatic longint project_axis(longint a, longint z, logic [63:0] f,
                                           logic [63:0] c);
      logic [63:0] q, off;
      q = (mag(a) << 16) / mag(z);
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      off = (f * q) >> 16;
      return (((a < 0) != (z < 0)) ? -longint'(off) : longint'(off)) + longint'(c);
   endfunction

   function automatic bit near_in_3d(vec3_type c, req_item_type it);
      logic [63:0] t2, acc, d, sq;
      longint obs [3];
      obs[0] = it.image_x; obs[1] = it.image_y; obs[2] = it.image_z;
      t2 = radius_3d * radius_3d;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         d = mag(c[i] - obs[i]);
         if (d >= radius_3d) return 0;
         sq = d * d;
         if (sq >= t2 - acc) return 0;
         acc += sq;
      end
      return 1;
   endfunction

   // per-beat prediction of the scoring state and of any result
   task automatic predict_beat(req_item_type it);
      vec3_type m, c;
      longint du, dv;
      logic [63:0] sq_dist, s;
      score_item_type exp;
      case (it.action)
         ACT_LOAD: if (it.pose_index < POSE_WORDS) pose_regs[it.pose_index] = it.pose_value;
         ACT_POINT: begin
            n_points++;
            if (!aborted) begin
               m[0] = it.model_x; m[1] = it.model_y; m[2] = it.model_z;
               to_camera(pose_regs, m, c);
               if (c[2] != 0) begin
                  du = project_axis(c[0], c[2], cam_fx, cam_cx) - longint'(it.image_u);
                  dv = project_axis(c[1], c[2], cam_fy, cam_cy) - longint'(it.image_v);
                  if (mag(du) < radius && mag(dv) < radius) begin
                     sq_dist = mag(du) * mag(du) + mag(dv) * mag(dv);
                     if (sq_dist < radius * radius) begin
                        if (c[2] < 0) begin
                           aborted = 1;
                           score_sum = 0;
                           depth_sum = 0;
                        end else begin
                           score_sum = add_sat(score_sum, radius - root_floor(sq_dist));
                           if (depth_mode && it.has_depth && near_in_3d(c, it))
                              depth_sum = add_sat(depth_sum, radius);
                        end
                     end
                  end
               end
            end
         end
         ACT_END: begin
            exp.score = 0; exp.behind = 0; exp.rejected = 0;
            if (aborted) begin
               exp.behind = 1;
               n_aborts++;
            end else begin
               s = score_sum;
               if (depth_mode && s > 0 && depth_sum <= (s - 1) / DEPTH_RATIO) begin
                  s = 0;
                  exp.rejected = 1;
                  n_rejects++;
               end
               exp.score = s[OUT_SCORE_W-1:0];
            end
            score_q.insert(score_q.size(), exp);
            score_sum = 0;
            depth_sum = 0;
            aborted = 0;
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 0;
         score_sum = 0; depth_sum = 0; aborted = 0;
         foreach (pose_regs[i]) pose_regs[i] = 0;
      end else begin
         if (req.valid && req.ready) begin
            predict_beat(cur_item);
            idle_cycles = 0;
         end
         if (!(req.valid && !req.ready)) begin
            if (gap > 0) begin
               gap--;
               req.valid <= 0;
            end else if (pending_q.size() > 0) begin
               cur_item = pending_q.pop_front();
               req.action <= cur_item.action;
               req.pose_index <= cur_item.pose_index;
               req.pose_value <= cur_item.pose_value;
               req.model_x <= cur_item.model_x;
               req.model_y <= cur_item.model_y;
               req.model_z <= cur_item.model_z;
               req.image_u <= cur_item.image_u;
               req.image_v <= cur_item.image_v;
               req.image_has_depth <= cur_item.has_depth;
               req.image_x <= cur_item.image_x;
               req.image_y <= cur_item.image_y;
               req.image_z <= cur_item.image_z;
               req.valid <= 1;
               if ($urandom_range(0, 40) == 0) burst = !burst;
               gap = burst ? 0 : $urandom_range(0, 19);
            end else req.valid <= 0;
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
         stall = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            idle_cycles = 0;
            n_scores++;
            if (score_q.size() == 0) begin
               $display("%0t: result with none expected: score %h behind %b rejected %b",
                        $time, rsp.score, rsp.behind_camera, rsp.depth_rejected);
               fails++;
            end else begin
               score_item_type exp;
               exp = score_q.pop_front();
               if (rsp.score !== exp.score) begin
                  $display("%0t: score expected %h actual %h", $time, exp.score, rsp.score);
                  fails++;
               end
               if (rsp.behind_camera !== exp.behind) begin
                  $display("%0t: behind_camera expected %b actual %b", $time, exp.behind,
                           rsp.behind_camera);
                  fails++;
               end
               if (rsp.depth_rejected !== exp.rejected) begin
                  $display("%0t: depth_rejected expected %b actual %b", $time,
                           exp.rejected, rsp.depth_rejected);
                  fails++;
               end
            end
            stall = burst ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            stall--;
            rsp.ready <= 0;
         end else rsp.ready <= 1;
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      idle_cycles = 0;
      case (idx)
         REG_FOCAL_X:    cam_fx = value;
         REG_FOCAL_Y:    cam_fy = value;
         REG_CENTER_X:   cam_cx = value;
         REG_CENTER_Y:   cam_cy = value;
         REG_DIST:       radius = value[DIST_W-1:0];
         REG_DIST_3D:    radius_3d = value;
         REG_DEPTH_MODE: depth_mode = value[0];
         default: ;
      endcase
   endtask

   task automatic set_camera(logic [31:0] fx, fy, cx, cy, r, r3, logic mode);
      csr_write(REG_FOCAL_X, fx);
      csr_write(REG_FOCAL_Y, fy);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_DIST, r);
      csr_write(REG_DIST_3D, r3);
      csr_write(REG_DEPTH_MODE, {31'd0, mode});
   endtask

   task automatic wait_idle();
      wait (pending_q.size() == 0 && !req.valid && score_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_item_type blank_item(logic [1:0] act);
      req_item_type it;
      it = '{default: 0};
      it.action = act;
      return it;
   endfunction

   task automatic push_load(int idx, logic [31:0] value);
      req_item_type it;
      it = blank_item(ACT_LOAD);
      it.pose_index = 4'(idx);
      it.pose_value = value;
      if (idx < POSE_WORDS) gen_pose[idx] = value;
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic push_end();
      pending_q.insert(pending_q.size(), blank_item(ACT_END));
   endtask

   function automatic req_item_type noise_item();
      req_item_type it;
      it.action = 2'($urandom_range(0, 3));
      it.pose_index = 4'($urandom_range(0, 15));
      it.pose_value = $urandom;
      it.model_x = $urandom; it.model_y = $urandom; it.model_z = $urandom;
      it.image_u = $urandom; it.image_v = $urandom;
      it.has_depth = 1'($urandom_range(0, 1));
      it.image_x = $urandom; it.image_y = $urandom; it.image_z = $urandom;
      return it;
   endfunction

   // point aimed at its own projection, moved by up to spread per image axis and spread_3d in 3d
   task automatic push_point(longint mx, longint my, longint mz, longint spread,
                             longint spread_3d, logic has_depth);
      req_item_type it;
      vec3_type m, c;
      m[0] = mx; m[1] = my; m[2] = mz;
      to_camera(gen_pose, m, c);
      it = blank_item(ACT_POINT);
      it.model_x = 32'(mx); it.model_y = 32'(my); it.model_z = 32'(mz);
      if (c[2] != 0) begin
         it.image_u = 32'(project_axis(c[0], c[2], cam_fx, cam_cx)
                      + longint'($urandom_range(0, 2 * spread)) - spread);
         it.image_v = 32'(project_axis(c[1], c[2], cam_fy, cam_cy)
                      + longint'($urandom_range(0, 2 * spread)) - spread);
      end
      it.has_depth = has_depth;
      it.image_x = 32'(c[0] + longint'($urandom_range(0, 2 * spread_3d)) - spread_3d);
      it.image_y = 32'(c[1] + longint'($urandom_range(0, 2 * spread_3d)) - spread_3d);
      it.image_z = 32'(c[2] + longint'($urandom_range(0, 2 * spread_3d)) - spread_3d);
      pending_q.insert(pending_q.size(), it);
   endtask

   task automatic load_pose(bit rotate, longint tz);
      for (int i = 0; i < ROT_WORDS; i++) begin
         if (rotate) push_load(i, $urandom_range(0, 32'h7000_0000) - 32'h3800_0000);
         else push_load(i, (i % 4 == 0) ? 32'h4000_0000 : 32'h0);
      end
      push_load(9, $urandom_range(0, 4 << 16) - (2 << 16));
      push_load(10, $urandom_range(0, 4 << 16) - (2 << 16));
      push_load(11, 32'(tz));
   endtask

   initial begin
      req_item_type it;
      longint r, r3;
      foreach (gen_pose[i]) gen_pose[i] = 0;
      cam_fx = 0; cam_fy = 0; cam_cx = 0; cam_cy = 0;
      radius = 0; radius_3d = 0; depth_mode = 0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed: typical camera, 3d rule on
      set_camera(500 << 16, 480 << 16, 320 << 16, 240 << 16, 4 << 16, 1 << 16, 1);
      load_pose(0, 10 << 16);
      push_point(0, 0, 0, 0, 0, 1);                       // exact hit, 3d agrees
      push_point(1 << 16, -(1 << 16), 2 << 16, 1 << 16, 1 << 15, 1);
      push_point(0, 0, -(10 << 16), 0, 0, 1);             // zero depth
      push_point(32'sh7FFF_FFFF, -32'sh8000_0000, 3 << 16, 1 << 16, 0, 0);
      push_point(-(1 << 16), 1 << 16, 0, 100 << 16, 0, 1); // likely outlier
      it = blank_item(2'd3);                               // unused action
      pending_q.insert(pending_q.size(), it);
      push_load(12, 32'hFFFF_FFFF);                        // out-of-range index
      push_load(15, 32'h1234_5678);
      push_end();
      push_point(0, 0, 0, 1 << 15, 0, 0);                  // inliers without depth
      push_point(1 << 15, 0, 0, 1 << 15, 0, 0);
      push_end();                                          // depth rule rejects
      push_point(0, 0, -(20 << 16), 0, 0, 1);              // behind camera inlier
      push_point(0, 0, 0, 0, 0, 1);                        // ignored after abort
      push_end();
      push_end();                                          // empty pass
      wait_idle();

      // random phases over a spread of camera settings
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: set_camera(0, 0, 0, 0, 0, 0, 0);
            1: set_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          24'hFF_FFFF, 32'hFFFF_FFFF, 1);
            default: set_camera($urandom_range(100, 2000) << 16,
                                $urandom_range(100, 2000) << 16,
                                $urandom_range(0, 1000) << 16,
                                $urandom_range(0, 1000) << 16,
                                $urandom_range(1 << 14, 16 << 16),
                                $urandom_range(1 << 14, 4 << 16),
                                1'($urandom_range(0, 1)));
         endcase
         r = radius;
         r3 = radius_3d < 64'd8 << 16 ? radius_3d : 64'd8 << 16;
         load_pose(1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0) ?
                   -longint'($urandom_range(5, 40) << 16) :
                   longint'($urandom_range(5, 40) << 16));
         for (int k = 0; k < 42; k++) begin
            case ($urandom_range(0, 19))
               0, 1, 2: pending_q.insert(pending_q.size(), noise_item());
               3, 4:    push_end();
               5:       push_load($urandom_range(0, 11), $urandom);
               default: push_point(longint'($urandom_range(0, 4 << 16)) - (2 << 16),
                                   longint'($urandom_range(0, 4 << 16)) - (2 << 16),
                                   longint'($urandom_range(0, 4 << 16)) - (2 << 16),
                                   r, r3, 1'($urandom_range(0, 1)));
            endcase
         end
         if ($urandom_range(0, 2) != 0) push_end();
         wait_idle();
      end
      push_end();
      wait_idle();

      $display("covered %0d point beats and %0d scores, %0d behind-camera passes,",
               n_points, n_scores, n_aborts);
      $display("%0d depth rejections, across 13 camera settings", n_rejects);
      if (fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
